// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/alse_pkg.sv =====
// Shared types and constants of the array list shift engine.
`timescale 1ns / 1ps

package alse_pkg;

    localparam int CAPACITY = 64;

    // Action codes
    localparam logic [2:0] ACT_APPEND  = 3'd0;
    localparam logic [2:0] ACT_PREPEND = 3'd1;
    localparam logic [2:0] ACT_INSERT  = 3'd2;
    localparam logic [2:0] ACT_DROP_HD = 3'd3;
    localparam logic [2:0] ACT_DROP_TL = 3'd4;
    localparam logic [2:0] ACT_DROP_AR = 3'd5;
    localparam logic [2:0] ACT_DUMP    = 3'd6;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOKEY = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic               is_element;
        logic               last;
        logic [1:0]         status;
        logic [6:0]         count;
    } result_t;

endpackage

// ===== rtl/alse_mem.sv =====
// Word store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module alse_mem #(
    parameter int DEPTH = alse_pkg::CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/array_list_shift_engine_core.sv =====
// Top level: list controller sequencing read-modify-write sweeps over the word store.
// Drop last and status-only actions leave the store alone and append writes one word;
//   the other edits shift words, insert and drop around after a key search.
// Throughput: one item at a time, busy stays high until the item's work is done;
//   a dump emits one word per cycle from registered read data.
// Reset clears the word count and control state; the store itself is not cleared.
`timescale 1ns / 1ps

module array_list_shift_engine_core #(
    parameter int CAPACITY = alse_pkg::CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  alse_pkg::item_t  item,
    output logic             strobe,
    output alse_pkg::result_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRCH = 6'b000010,
        S_SHUP = 6'b000100,
        S_SHDN = 6'b001000,
        S_DUMP = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        act_reg, act_next;
    logic [31:0]       key_reg, key_next;
    logic [31:0]       nv_reg, nv_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [LW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              more_reg, more_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     paddr_reg, paddr_next;
    logic              second_reg, second_next;
    logic [1:0]        stat_reg, stat_next;
    logic              strobe_reg, strobe_next;
    alse_pkg::result_t res_reg, res_next;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [31:0]       wdata, rdata;

    logic [LW:0]       len_x, lo_x, pad_x, ptr_inc;
    logic              full;

    alse_mem #(
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign len_x   = {1'b0, len_reg};
    assign lo_x    = {1'b0, lo_reg};
    assign pad_x   = (LW+1)'(paddr_reg);
    assign ptr_inc = (LW+1)'(ptr_reg) + 1'b1;
    assign full    = (len_reg == LW'(CAPACITY));

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

    // Next-state and memory control
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        nv_next     = nv_reg;
        len_next    = len_reg;
        lo_next     = lo_reg;
        ptr_next    = ptr_reg;
        more_next   = more_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        second_next = second_reg;
        stat_next   = stat_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        we          = 1'b0;
        waddr       = paddr_reg;
        wdata       = rdata;
        re          = 1'b0;
        raddr       = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next  = item.action;
                    key_next  = item.key;
                    nv_next   = item.new_value;
                    stat_next = alse_pkg::ST_DONE;
                    state_next = S_FIN;
                    unique case (item.action)
                        alse_pkg::ACT_APPEND:
                        begin
                            if (full)
                            begin
                                stat_next = alse_pkg::ST_FULL;
                            end
                            else
                            begin
                                lo_next    = len_reg;
                                ptr_next   = AW'(len_x - 1'b1);
                                more_next  = 1'b0;
                                state_next = S_SHUP;
                            end
                        end
                        alse_pkg::ACT_PREPEND:
                        begin
                            if (full)
                            begin
                                stat_next = alse_pkg::ST_FULL;
                            end
                            else
                            begin
                                lo_next    = '0;
                                ptr_next   = AW'(len_x - 1'b1);
                                more_next  = (len_reg != '0);
                                state_next = S_SHUP;
                            end
                        end
                        alse_pkg::ACT_INSERT:
                        begin
                            if (full)
                            begin
                                stat_next = alse_pkg::ST_FULL;
                            end
                            else if (len_reg == '0)
                            begin
                                stat_next = alse_pkg::ST_NOKEY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                more_next  = 1'b1;
                                state_next = S_SRCH;
                            end
                        end
                        alse_pkg::ACT_DROP_HD:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next = alse_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                lo_next     = '0;
                                ptr_next    = AW'(1);
                                more_next   = (len_x > (LW+1)'(1));
                                second_next = 1'b0;
                                state_next  = S_SHDN;
                            end
                        end
                        alse_pkg::ACT_DROP_TL:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next = alse_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                len_next = len_reg - 1'b1;
                            end
                        end
                        alse_pkg::ACT_DROP_AR:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next = alse_pkg::ST_NOKEY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                more_next  = 1'b1;
                                state_next = S_SRCH;
                            end
                        end
                        alse_pkg::ACT_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next = alse_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                more_next  = 1'b1;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            stat_next = alse_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Key search: one read issued per cycle, compared against the key in the following cycle
            S_SRCH:
            begin
                if (more_reg)
                begin
                    re         = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + 1'b1;
                    more_next  = (ptr_inc < len_x);
                end
                if (pend_reg)
                begin
                    if (rdata == key_reg)
                    begin
                        pend_next = 1'b0;
                        if (act_reg == alse_pkg::ACT_INSERT)
                        begin
                            lo_next    = LW'(pad_x);
                            ptr_next   = AW'(len_x - 1'b1);
                            more_next  = 1'b1;
                            state_next = S_SHUP;
                        end
                        else if ((pad_x + 1'b1) < len_x)
                        begin
                            lo_next     = LW'(pad_x + 1'b1);
                            ptr_next    = AW'(pad_x + 2'd2);
                            more_next   = ((pad_x + 2'd2) < len_x);
                            second_next = (paddr_reg != '0);
                            state_next  = S_SHDN;
                        end
                        else if (paddr_reg != '0)
                        begin
                            lo_next     = LW'(pad_x - 1'b1);
                            ptr_next    = paddr_reg;
                            more_next   = 1'b1;
                            second_next = 1'b0;
                            state_next  = S_SHDN;
                        end
                        else
                        begin
                            stat_next  = alse_pkg::ST_DONE;
                            state_next = S_FIN;
                        end
                    end
                    else if (!more_reg)
                    begin
                        stat_next  = alse_pkg::ST_NOKEY;
                        state_next = S_FIN;
                    end
                end
            end

            // Shift up: read high to low, write one place higher, then fill the gap
            S_SHUP:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = paddr_reg + 1'b1;
                    wdata = rdata;
                end
                if (more_reg)
                begin
                    re         = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    if (ptr_reg == lo_reg[AW-1:0])
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
                if (!more_reg && !pend_reg)
                begin
                    we         = 1'b1;
                    waddr      = lo_reg[AW-1:0];
                    wdata      = nv_reg;
                    len_next   = len_reg + 1'b1;
                    stat_next  = alse_pkg::ST_DONE;
                    state_next = S_FIN;
                end
            end

            // Shift down: read low to high, write one place lower, then shorten
            S_SHDN:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = paddr_reg - 1'b1;
                    wdata = rdata;
                end
                if (more_reg)
                begin
                    re         = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + 1'b1;
                    more_next  = (ptr_inc < len_x);
                end
                if (!more_reg && !pend_reg)
                begin
                    len_next = len_reg - 1'b1;
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        lo_next     = LW'(lo_x - 2'd2);
                        ptr_next    = AW'(lo_x - 1'b1);
                        more_next   = (lo_x < len_x);
                    end
                    else
                    begin
                        stat_next  = alse_pkg::ST_DONE;
                        state_next = S_FIN;
                    end
                end
            end

            // Dump: stream words in order
            S_DUMP:
            begin
                if (more_reg)
                begin
                    re         = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = ptr_reg;
                    ptr_next   = ptr_reg + 1'b1;
                    more_next  = (ptr_inc < len_x);
                end
                if (pend_reg)
                begin
                    strobe_next         = 1'b1;
                    res_next.element    = rdata;
                    res_next.is_element = 1'b1;
                    res_next.last       = ((pad_x + 1'b1) == len_x);
                    res_next.status     = alse_pkg::ST_DONE;
                    res_next.count      = 7'(len_reg);
                end
                if (!more_reg && !pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            // Single status item
            S_FIN:
            begin
                strobe_next         = 1'b1;
                res_next.element    = '0;
                res_next.is_element = 1'b0;
                res_next.last       = 1'b1;
                res_next.status     = stat_reg;
                res_next.count      = 7'(len_reg);
                state_next          = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            more_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            second_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            more_reg   <= more_next;
            pend_reg   <= pend_next;
            second_reg <= second_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        nv_reg    <= nv_next;
        lo_reg    <= lo_next;
        ptr_reg   <= ptr_next;
        paddr_reg <= paddr_next;
        stat_reg  <= stat_next;
        res_reg   <= res_next;
    end

endmodule

// ===== rtl/alse_checker.sv =====
// Port-level checker for the list engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alse_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              strobe,
    input alse_pkg::result_t result
);

    // An accepted item always makes the engine busy in the next cycle
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not set after accept")

    // A status-only item is always the final one
    `ASSERT_SAME(a_status_last, clk, rst_n, strobe && !result.is_element, result.last, "status item not last")

    // Dumped words always carry the done status
    `ASSERT_SAME(a_elem_status, clk, rst_n, strobe && result.is_element, result.status == alse_pkg::ST_DONE, "bad status on word")

    // A non-word item carries a zero element
    `ASSERT_SAME(a_elem_zero, clk, rst_n, strobe && !result.is_element, result.element == 32'sd0, "nonzero element")

endmodule

bind array_list_shift_engine_core alse_checker u_alse_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .strobe(strobe),
    .result(result)
);

// ===== test/tb_top.sv =====
// Testbench for the array list shift engine: directed and random list edits checked by a model.
`timescale 1ns / 1ps

module tb_top;

    localparam int CAP = alse_pkg::CAPACITY;
    localparam int CYCLE_LIMIT = 400000;

    // Action code with no defined edit
    localparam logic [2:0] ACT_NOP = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    alse_pkg::item_t item = '0;
    logic strobe;
    alse_pkg::result_t result;

    // List model state
    logic signed [31:0] list_words[$];
    alse_pkg::result_t expected_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit calm = 1'b0;

    array_list_shift_engine_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item(item), .strobe(strobe), .result(result)
    );

    always #5 clk = ~clk;

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    function automatic alse_pkg::result_t status_word(input logic [1:0] st);
        alse_pkg::result_t r;
        r = '0;
        r.last = 1'b1;
        r.status = st;
        r.count = 7'(list_words.size());
        return r;
    endfunction

    function automatic int find_word(input logic signed [31:0] k);
        for (int i = 0; i < list_words.size(); i++)
            if (list_words[i] == k) return i;
        return -1;
    endfunction

    // Apply one item to the list model and queue its results
    task automatic predict_list_edit(input alse_pkg::item_t it);
        int pos;
        alse_pkg::result_t r;
        case (it.action)
            alse_pkg::ACT_APPEND, alse_pkg::ACT_PREPEND:
                if (list_words.size() >= CAP)
                    expected_q.push_back(status_word(alse_pkg::ST_FULL));
                else
                begin
                    if (it.action == alse_pkg::ACT_APPEND) list_words.push_back(it.new_value);
                    else list_words.push_front(it.new_value);
                    expected_q.push_back(status_word(alse_pkg::ST_DONE));
                end
            alse_pkg::ACT_INSERT:
            begin
                pos = find_word(it.key);
                if (list_words.size() >= CAP)
                    expected_q.push_back(status_word(alse_pkg::ST_FULL));
                else if (pos < 0) expected_q.push_back(status_word(alse_pkg::ST_NOKEY));
                else
                begin
                    list_words.insert(pos, it.new_value);
                    expected_q.push_back(status_word(alse_pkg::ST_DONE));
                end
            end
            alse_pkg::ACT_DROP_HD, alse_pkg::ACT_DROP_TL:
                if (list_words.size() == 0)
                    expected_q.push_back(status_word(alse_pkg::ST_EMPTY));
                else
                begin
                    if (it.action == alse_pkg::ACT_DROP_HD) void'(list_words.pop_front());
                    else void'(list_words.pop_back());
                    expected_q.push_back(status_word(alse_pkg::ST_DONE));
                end
            alse_pkg::ACT_DROP_AR:
            begin
                pos = find_word(it.key);
                if (pos < 0) expected_q.push_back(status_word(alse_pkg::ST_NOKEY));
                else
                begin
                    if (pos + 1 < list_words.size()) list_words.delete(pos + 1);
                    if (pos > 0) list_words.delete(pos - 1);
                    expected_q.push_back(status_word(alse_pkg::ST_DONE));
                end
            end
            alse_pkg::ACT_DUMP:
                if (list_words.size() == 0)
                    expected_q.push_back(status_word(alse_pkg::ST_EMPTY));
                else
                    for (int i = 0; i < list_words.size(); i++)
                    begin
                        r = '0;
                        r.element = list_words[i];
                        r.is_element = 1'b1;
                        r.last = (i == list_words.size() - 1);
                        r.status = alse_pkg::ST_DONE;
                        r.count = 7'(list_words.size());
                        expected_q.push_back(r);
                    end
            default:
                expected_q.push_back(status_word(alse_pkg::ST_DONE));
        endcase
    endtask

    // Result checker
    always @(posedge clk)
    begin
        alse_pkg::result_t e;
        if (rst_n && strobe)
        begin
            if (expected_q.size() == 0) report("result with nothing expected");
            else
            begin
                e = expected_q.pop_front();
                if (result.element !== e.element) report("element");
                if (result.is_element !== e.is_element) report("is_element");
                if (result.last !== e.last) report("last");
                if (result.status !== e.status) report("status");
                if (result.count !== e.count) report("count");
            end
        end
    end

    // Send one item; random gaps unless calm
    task automatic send_item(input logic [2:0] act, input logic signed [31:0] k,
                             input logic signed [31:0] v);
        alse_pkg::item_t it;
        it.action = act;
        it.key = k;
        it.new_value = v;
        if (!calm)
            while ($urandom_range(99) < 6) @(posedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_list_edit(it);
        start <= 1'b0;
        // The engine shows busy in the cycle after an accept
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (CAP + 8) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_word();
        if (list_words.size() != 0 && $urandom_range(3) != 0)
            return list_words[$urandom_range(list_words.size() - 1)];
        return $urandom_range(7);
    endfunction

    task automatic test_empty_list();
        send_item(alse_pkg::ACT_DROP_HD, 0, 0);
        send_item(alse_pkg::ACT_DROP_TL, 0, 0);
        send_item(alse_pkg::ACT_DUMP, 0, 0);
        send_item(alse_pkg::ACT_INSERT, 5, 1);
        send_item(alse_pkg::ACT_DROP_AR, 5, 0);
        send_item(ACT_NOP, 0, 0);
    endtask

    task automatic test_edits();
        send_item(alse_pkg::ACT_APPEND, 0, 32'sh7fffffff);
        send_item(alse_pkg::ACT_DROP_AR, 32'sh7fffffff, 0);
        send_item(alse_pkg::ACT_PREPEND, 0, 32'sh80000000);
        send_item(alse_pkg::ACT_APPEND, 0, 32'shffffffff);
        send_item(alse_pkg::ACT_INSERT, 32'shffffffff, 0);
        send_item(alse_pkg::ACT_INSERT, 32'sh12345678, 9);
        send_item(alse_pkg::ACT_DUMP, 0, 0);
        send_item(alse_pkg::ACT_DROP_AR, 32'sh80000000, 0);
        send_item(alse_pkg::ACT_DROP_AR, 0, 0);
        send_item(alse_pkg::ACT_DUMP, 0, 0);
        send_item(alse_pkg::ACT_DROP_HD, 0, 0);
        send_item(alse_pkg::ACT_DROP_TL, 0, 0);
        // Pause until every expected result is in
        wait_drained();
    endtask

    task automatic test_full_list();
        while (list_words.size() < CAP) send_item(alse_pkg::ACT_APPEND, 0, $urandom);
        send_item(alse_pkg::ACT_APPEND, 0, 1);
        send_item(alse_pkg::ACT_PREPEND, 0, 2);
        send_item(alse_pkg::ACT_INSERT, 32'sh0badf00d, 3);
        send_item(alse_pkg::ACT_DUMP, 0, 0);
        // Drain mostly two words at a time
        while (list_words.size() > 4)
            send_item(alse_pkg::ACT_DROP_AR, list_words[list_words.size() / 2], 0);
    endtask

    task automatic test_random_ops(input int n);
        logic [2:0] act;
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3 && i < n / 2);
            act = $urandom_range(99) < 2 ? ACT_NOP : 3'($urandom_range(6));
            if (act == alse_pkg::ACT_DUMP && $urandom_range(2) != 0) act = alse_pkg::ACT_APPEND;
            if ($urandom_range(9) == 0)
                send_item(act, $urandom, $urandom);
            else
                send_item(act, pick_word(), $urandom_range(7));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_edits();
        test_full_list();
        test_random_ops(60);
        send_item(alse_pkg::ACT_DUMP, 0, 0);
        wait_drained();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== array_list_shift_engine_core.f =====
+incdir+rtl
rtl/alse_pkg.sv
rtl/alse_mem.sv
rtl/array_list_shift_engine_core.sv
rtl/alse_checker.sv
test/tb_top.sv
